[hdl/linear_range_scaler_core_assert.svh]
// Assertion macros used by the checker file of the range scaler.
`ifndef LINEAR_RANGE_SCALER_CORE_ASSERT_SVH
`define LINEAR_RANGE_SCALER_CORE_ASSERT_SVH

// property checked at every edge outside reset
`define LRS_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define LRS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

[hdl/lrs_pkg.sv]
// Shared widths, register codes and pipeline word types of the range scaler.
`default_nettype none
package lrs_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int XLEN       = 32;
	localparam int CFG_AW     = 2;

	typedef enum logic [CFG_AW-1:0] {
		REG_VALUE_MIN = 2'd0,
		REG_VALUE_MAX = 2'd1,
		REG_SCALE_MIN = 2'd2,
		REG_SCALE_MAX = 2'd3
	} cfg_reg_t;

	typedef logic signed [DATA_WIDTH-1:0] dword_t;

	// word carried through the restoring divider
	typedef struct packed {
		logic [DATA_WIDTH-1:0] rem;
		logic [DATA_WIDTH:0]   num;
		logic [DATA_WIDTH:0]   quo;
		logic [DATA_WIDTH-1:0] dvs;
		logic                  neg;
		logic                  pre_ovf;
		logic                  zero;
		dword_t                smin;
	} lrs_div_t;

	typedef struct packed {
		logic [XLEN-1:0] scaled;
		logic            overflow;
		logic            span_zero;
	} lrs_word_t;

endpackage
`default_nettype wire

[hdl/linear_range_scaler_core.sv]
// Top level of the linear range scaler: config registers, pipeline and output skid.
// Throughput: one word per cycle while the skid entry is empty; the divider is DATA_WIDTH + 1 pipelined stages.
// A two-entry output register / skid pair lets the pipe run while a result waits.
// Reset (arst_n low, asynchronous) empties the pipe and loads value/scale ranges [0,1].
`default_nettype none
module linear_range_scaler_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [lrs_pkg::CFG_AW-1:0] cfg_addr,
	input  wire logic [lrs_pkg::XLEN-1:0]   cfg_wdata,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [lrs_pkg::XLEN-1:0]   s_tdata,   // [31:0] sample
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [lrs_pkg::XLEN-1:0]        m_tdata,   // [31:0] scaled
	output logic [1:0]                      m_tuser    // [0] overflow, [1] span_zero
);
	import lrs_pkg::*;

	localparam int W    = DATA_WIDTH;
	localparam int NDIV = W + 1;

	localparam dword_t SAT_MAX = {1'b0, {(W-1){1'b1}}};
	localparam dword_t SAT_MIN = {1'b1, {(W-1){1'b0}}};

	dword_t vmin_q, vmax_q, smin_q, smax_q;

	logic en;

	// stage 1: differences
	logic       v_s1;
	logic [W:0] da_s1, db_s1, dd_s1;
	logic       zero_s1;
	dword_t     smin_s1;

	// stage 2: magnitudes
	logic         v_s2;
	logic [W-1:0] ma_s2, mb_s2, md_s2;
	logic         neg_s2, zero_s2;
	dword_t       smin_s2;

	// stage 3: product
	logic           v_s3;
	logic [2*W-1:0] prod_s3;
	logic [W-1:0]   md_s3;
	logic           neg_s3, zero_s3;
	dword_t         smin_s3;

	// stage 4: divider chain
	lrs_div_t div_d [NDIV+1];
	logic     div_v [NDIV+1];
	logic [W-1:0] prod_hi;

	// stage 5: rounded quotient
	logic         v_s5;
	logic [W+1:0] q_s5;
	logic         neg_s5, pre_ovf_s5, zero_s5;
	dword_t       smin_s5;

	logic [W:0]   na, nb, nd;
	logic         half;
	lrs_div_t     div_last;

	logic signed [W+2:0] sum;
	logic                out_rng;
	dword_t              res_c;
	logic                ovf_c;
	lrs_word_t           word_c;

	logic      out_v_q, skid_v_q;
	lrs_word_t out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmin_q <= dword_t'(0);
			vmax_q <= dword_t'(1);
			smin_q <= dword_t'(0);
			smax_q <= dword_t'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_VALUE_MIN: vmin_q <= cfg_wdata[W-1:0];
				REG_VALUE_MAX: vmax_q <= cfg_wdata[W-1:0];
				REG_SCALE_MIN: smin_q <= cfg_wdata[W-1:0];
				REG_SCALE_MAX: smax_q <= cfg_wdata[W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipe holds while the skid entry is occupied
	assign en       = !skid_v_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s5 <= div_v[NDIV];
		end
	end

	assign na = -da_s1;
	assign nb = -db_s1;
	assign nd = -dd_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			da_s1   <= {s_tdata[W-1], s_tdata[W-1:0]} - {vmin_q[W-1], vmin_q};
			db_s1   <= {smax_q[W-1], smax_q} - {smin_q[W-1], smin_q};
			dd_s1   <= {vmax_q[W-1], vmax_q} - {vmin_q[W-1], vmin_q};
			zero_s1 <= vmax_q == vmin_q;
			smin_s1 <= smin_q;

			ma_s2   <= da_s1[W] ? na[W-1:0] : da_s1[W-1:0];
			mb_s2   <= db_s1[W] ? nb[W-1:0] : db_s1[W-1:0];
			md_s2   <= dd_s1[W] ? nd[W-1:0] : dd_s1[W-1:0];
			neg_s2  <= da_s1[W] ^ db_s1[W] ^ dd_s1[W];
			zero_s2 <= zero_s1;
			smin_s2 <= smin_s1;

			prod_s3 <= {{W{1'b0}}, ma_s2} * {{W{1'b0}}, mb_s2};
			md_s3   <= md_s2;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			smin_s3 <= smin_s2;
		end
	end

	// quotient of 2^(W+1) or more saturates whatever scale_min is
	assign prod_hi = {1'b0, prod_s3[2*W-1:W+1]};

	always_comb begin
		div_d[0]         = '0;
		div_d[0].rem     = prod_hi;
		div_d[0].num     = prod_s3[W:0];
		div_d[0].dvs     = md_s3;
		div_d[0].neg     = neg_s3;
		div_d[0].pre_ovf = prod_hi >= md_s3;
		div_d[0].zero    = zero_s3;
		div_d[0].smin    = smin_s3;
	end
	assign div_v[0] = v_s3;

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		lrs_div_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_v   (div_v[k]),
			.in_d   (div_d[k]),
			.out_v  (div_v[k+1]),
			.out_d  (div_d[k+1])
		);
	end

	assign div_last = div_d[NDIV];
	// round half away from zero on the magnitude
	assign half     = div_last.rem >= (div_last.dvs - div_last.rem);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s5       <= {1'b0, div_last.quo} + {{(W+1){1'b0}}, half};
			neg_s5     <= div_last.neg;
			pre_ovf_s5 <= div_last.pre_ovf;
			zero_s5    <= div_last.zero;
			smin_s5    <= div_last.smin;
		end
	end

	assign sum     = neg_s5 ? ({{3{smin_s5[W-1]}}, smin_s5} - {1'b0, q_s5})
	                        : ({{3{smin_s5[W-1]}}, smin_s5} + {1'b0, q_s5});
	assign out_rng = !((&sum[W+2:W-1]) || !(|sum[W+2:W-1]));

	always_comb begin
		if (zero_s5) begin
			res_c = smin_s5;
			ovf_c = 1'b0;
		end else if (pre_ovf_s5) begin
			res_c = neg_s5 ? SAT_MIN : SAT_MAX;
			ovf_c = 1'b1;
		end else if (out_rng) begin
			res_c = sum[W+2] ? SAT_MIN : SAT_MAX;
			ovf_c = 1'b1;
		end else begin
			res_c = sum[W-1:0];
			ovf_c = 1'b0;
		end
		word_c.scaled    = XLEN'(res_c);
		word_c.overflow  = ovf_c;
		word_c.span_zero = zero_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_tready) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || m_tready) begin
			out_v_q <= v_s5;
		end else if (v_s5) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_tready) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || m_tready) begin
			out_q <= word_c;
		end else begin
			skid_q <= word_c;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q.scaled;
	assign m_tuser  = {out_q.span_zero, out_q.overflow};

endmodule
`default_nettype wire

[hdl/lrs_div_stage.sv]
// One quotient bit of the pipelined restoring divider.
`default_nettype none
module lrs_div_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_v,
	input  wire lrs_pkg::lrs_div_t in_d,
	output logic                   out_v,
	output lrs_pkg::lrs_div_t      out_d
);
	import lrs_pkg::*;

	localparam int W = DATA_WIDTH;

	logic [W:0] trial;
	logic [W:0] diff;
	logic       ge;
	lrs_div_t   nxt;

	assign trial = {in_d.rem, in_d.num[W]};
	assign ge    = trial >= {1'b0, in_d.dvs};
	assign diff  = trial - {1'b0, in_d.dvs};

	always_comb begin
		nxt     = in_d;
		nxt.rem = ge ? diff[W-1:0] : trial[W-1:0];
		nxt.num = {in_d.num[W-1:0], 1'b0};
		nxt.quo = {in_d.quo[W-1:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

endmodule
`default_nettype wire

[hdl/lrs_checker.sv]
// Port-level checks of the range scaler and their bind to the top level.
`default_nettype none
`include "linear_range_scaler_core_assert.svh"
module lrs_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     s_tvalid,
	input wire logic                     s_tready,
	input wire logic                     m_tvalid,
	input wire logic                     m_tready,
	input wire logic [lrs_pkg::XLEN-1:0] m_tdata,
	input wire logic [1:0]               m_tuser
);
	import lrs_pkg::*;

	localparam logic [XLEN-1:0] SAT_HI = XLEN'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
	localparam logic [XLEN-1:0] SAT_LO = ~SAT_HI;

	property p_out_hold;
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser);
	endproperty

	property p_ovf_sat;
		m_tvalid && m_tuser[0] |-> m_tdata == SAT_HI || m_tdata == SAT_LO;
	endproperty

	property p_stall_full;
		!s_tready && s_tvalid |-> m_tvalid;
	endproperty

	`LRS_ASSERT(a_out_hold, clk, arst_n, p_out_hold, "result word changed while stalled")
	`LRS_ASSERT(a_zero_no_ovf, clk, arst_n, m_tvalid && m_tuser[1] |-> !m_tuser[0], "span_zero with overflow")
	`LRS_ASSERT(a_ovf_sat, clk, arst_n, p_ovf_sat, "overflow without saturated value")
	`LRS_ASSERT(a_stall_full, clk, arst_n, p_stall_full, "input stalled with no result waiting")
	`LRS_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !m_tvalid && s_tready, "not idle in reset")

endmodule

bind linear_range_scaler_core lrs_checker u_lrs_checker (.*);
`default_nettype wire
